// File: hdl/assert_macros.svh
// assertion macros for the rtl files (included by itrt_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)
`endif
`endif

// File: hdl/itrt_pkg.sv
// shared types, constants and helpers for integer_to_radix_text
package itrt_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DIGIT_LIMIT = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'd45;

  typedef struct packed {
    logic load;
    logic shift;
    logic finish;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic last_digit;
    logic out_free;
  } status_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DIGIT_LIMIT) begin
      res = CHAR_ZERO + {2'b00, d};
    end else begin
      res = CHAR_LOWER_A + {2'b00, d - DIGIT_LIMIT};
    end
    return res;
  endfunction

endpackage

// File: hdl/itrt_datapath.sv
// datapath: radix register, bit-serial radix conversion, digit store, output register
module itrt_datapath #(
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [itrt_pkg::RADIX_W-1:0]    cfg_wdata,
  input  logic [WORD_BITS-1:0]            value,
  input  itrt_pkg::cmd_t                  cmd,
  output itrt_pkg::status_t               status,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [itrt_pkg::CHAR_W-1:0]     out_char,
  output logic                            out_last
);

  localparam int DIGITS = WORD_BITS;
  localparam int NDIG_W = $clog2(DIGITS + 1);
  localparam int IDX_W  = $clog2(DIGITS);
  localparam int BIT_W  = $clog2(WORD_BITS);

  logic [itrt_pkg::RADIX_W-1:0] radix;
  logic [itrt_pkg::RADIX_W-1:0] base;
  logic [WORD_BITS-1:0]         mag;
  logic                         neg;
  logic [itrt_pkg::RADIX_W-1:0] digits [DIGITS];
  logic [itrt_pkg::RADIX_W-1:0] digits_next [DIGITS];
  logic [itrt_pkg::RADIX_W:0]   diff [DIGITS];
  logic [NDIG_W-1:0]            ndig;
  logic [NDIG_W-1:0]            ndig_next;
  logic [IDX_W-1:0]             idx;
  logic [BIT_W-1:0]             bit_cnt;

  logic [DIGITS-1:0] gen;
  logic [DIGITS-1:0] prop;
  logic [DIGITS:0]   sum;
  logic [DIGITS:0]   carry;
  logic              shift_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itrt_pkg::RADIX_RESET;
    end else if (cfg_wen) begin
      radix <= cfg_wdata;
    end
  end

  // doubling of the digit vector: each digit is a generate or propagate cell,
  // so all carries come out of one wide add
  always_comb begin
    shift_in = mag[WORD_BITS-1];
    for (int i = 0; i < DIGITS; i++) begin
      gen[i]  = {digits[i], 1'b0} >= {1'b0, base};
      prop[i] = {digits[i], 1'b1} == {1'b0, base};
    end
    sum   = {1'b0, gen | prop} + {1'b0, gen} + {{DIGITS{1'b0}}, shift_in};
    carry = sum ^ {1'b0, gen | prop} ^ {1'b0, gen};
    for (int i = 0; i < DIGITS; i++) begin
      diff[i] = {digits[i], carry[i]} - (carry[i+1] ? {1'b0, base}
                                                    : {(itrt_pkg::RADIX_W+1){1'b0}});
      digits_next[i] = diff[i][itrt_pkg::RADIX_W-1:0];
    end
    // digits above the count are zero, so only the carry into the top can grow it
    ndig_next = ndig + NDIG_W'(carry[ndig]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= value[WORD_BITS-1];
      mag     <= value[WORD_BITS-1] ? (~value + 1'b1) : value;
      base    <= itrt_pkg::clamp_radix(radix);
      ndig    <= '0;
      bit_cnt <= '0;
      for (int i = 0; i < DIGITS; i++) begin
        digits[i] <= '0;
      end
    end else if (cmd.shift) begin
      mag     <= {mag[WORD_BITS-2:0], 1'b0};
      ndig    <= ndig_next;
      bit_cnt <= bit_cnt + 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
        digits[i] <= digits_next[i];
      end
    end
    if (cmd.finish) begin
      // zero keeps one digit
      idx <= (ndig == '0) ? '0 : IDX_W'(ndig - 1'b1);
    end else if (cmd.emit_digit) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char <= itrt_pkg::CHAR_MINUS;
      out_last <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char <= itrt_pkg::digit_to_ascii(digits[idx]);
      out_last <= (idx == '0);
    end
  end

  assign status.conv_done  = (bit_cnt == BIT_W'(WORD_BITS - 1));
  assign status.neg        = neg;
  assign status.last_digit = (idx == '0);
  assign status.out_free   = !out_valid || out_ready;

endmodule

// File: hdl/itrt_ctrl.sv
// controller state machine: accept, convert, set up the digit pointer, then send sign (if negative) and digits
`include "assert_macros.svh"
module itrt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  itrt_pkg::status_t status,
  output itrt_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_FIN   = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (status.conv_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = status.neg ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.last_digit) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_PROP(a_one_cmd, clk, rst,
    $onehot0({cmd.load, cmd.shift, cmd.finish, cmd.emit_sign, cmd.emit_digit}))
  `ASSERT_PROP(a_emit_has_room, clk, rst,
    (cmd.emit_sign || cmd.emit_digit) |-> status.out_free)
  `ASSERT_PROP(a_load_starts_conv, clk, rst, cmd.load |=> (state == ST_CONV))
  `ASSERT_PROP(a_sign_before_digit, clk, rst, cmd.emit_sign |=> (state == ST_DIGIT))

endmodule

// File: hdl/integer_to_radix_text.sv
// top level of the integer to radix text converter
// Converts a signed two's complement integer into its text in a programmable
// radix (2..36), one ASCII character per output request, most significant
// digit first, with a leading '-' for negative values. Digits above nine use
// 'a'..'z'; the final character of each number has tlast set, no terminator.
// Input: s_axis_* carries one integer per request. Output: m_axis_* carries
// one character per request. cfg_wen/cfg_wdata write the radix; 0 or 1 act
// as 2, 37..63 act as 36. Write it only while the block is idle.
// Sequence: after acceptance the magnitude is folded into the digit register
// one bit per cycle, then the FIN state sets up the digit pointer, then one
// character (the '-' first, if negative) is loaded per cycle into the output
// register while the receiver keeps up.
// The next integer is accepted as soon as the last character is loaded,
// while it still waits in the output register.
// Reset: returns to idle, drops m_axis_tvalid and sets the radix to ten.
// A stalled receiver holds the current character and pauses the sequence.
module integer_to_radix_text #(
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [itrt_pkg::RADIX_W-1:0]        cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [WORD_BITS-1:0] value, zero padded to whole bytes
  input  logic [((WORD_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] character
  output logic [itrt_pkg::CHAR_W-1:0]         m_axis_tdata,
  output logic                                m_axis_tlast
);

  itrt_pkg::cmd_t    cmd;
  itrt_pkg::status_t status;

  itrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  itrt_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .value     (s_axis_tdata[WORD_BITS-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
